### hdl/sks_pkg.sv
// Shared types and constants for the sequence-keyed hash store.
`default_nettype none
package sks_pkg;

	localparam int NUM_BUCKETS_DEF  = 16;
	localparam int BUCKET_DEPTH_DEF = 8;
	localparam int HANDLE_BITS_DEF  = 16;

	localparam int KEY_W          = 32;
	localparam int HANDLE_PORT_W  = 16;
	localparam int CFG_W          = 5;
	localparam int DIV_STEP_BITS  = 8;
	localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 5'd16;

	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_GET    = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_PREP,
		S_EXEC,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_RESP
	} state_t;

endpackage
`default_nettype wire

### hdl/sequence_keyed_hash_store.sv
// Each request is divided, prepared and executed; an add or unused action code then responds,
// a lookup scans slots by a read and a compare each, and a remove hit moves each younger entry
// down. A new request is taken only once the last response is loaded. The modulo unit
// takes 8 key bits a cycle; one slot read and one write a cycle pace the scan and move loops.
// Reset clears every bucket fill count and sets the bucket count register to 16; slot contents are left
// as they are, since only slots below a bucket's fill count are ever used.
`default_nettype none
module sequence_keyed_hash_store
	import sks_pkg::*;
#(
	parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
	parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF,
	parameter int HANDLE_BITS  = HANDLE_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     wr_en,
	input  wire logic [CFG_W-1:0]         wr_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [1:0]               action,
	input  wire logic [KEY_W-1:0]         seq_key,
	input  wire logic [HANDLE_PORT_W-1:0] entry_handle,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [1:0]                    status,
	output logic [HANDLE_PORT_W-1:0]      found_handle
);

	// The count register cannot exceed its field, so buckets above that are never used.
	localparam int CfgMax      = (1 << CFG_W) - 1;
	localparam int UsedBuckets = (NUM_BUCKETS < CfgMax) ? NUM_BUCKETS : CfgMax;
	localparam int SlotTotal   = UsedBuckets * BUCKET_DEPTH;
	localparam int AddrW       = (SlotTotal > 1) ? $clog2(SlotTotal) : 1;
	localparam int BucketW     = (UsedBuckets > 1) ? $clog2(UsedBuckets) : 1;
	localparam int CntW        = $clog2(BUCKET_DEPTH + 1);
	localparam int HandleW     = (HANDLE_BITS < HANDLE_PORT_W) ? HANDLE_BITS : HANDLE_PORT_W;
	localparam int RemW        = CFG_W;
	localparam int DivSteps    = KEY_W / DIV_STEP_BITS;
	localparam int DivCntW     = (DivSteps > 1) ? $clog2(DivSteps) : 1;

	state_t state_q, state_d;

	logic [CFG_W-1:0]   cfg_q;
	logic [1:0]         act_q;
	logic [KEY_W-1:0]   key_q;
	logic [HandleW-1:0] hdl_q;
	logic [RemW-1:0]    eff_q;
	logic [RemW-1:0]    rem_q;
	logic [DivCntW-1:0] div_cnt_q;
	logic [BucketW-1:0] bucket_q;
	logic [AddrW-1:0]   base_q;
	logic [CntW-1:0]    fill_cur_q;
	logic [CntW-1:0]    k_q;
	logic [HandleW-1:0] res_q;
	logic [1:0]         st_q;
	logic [CntW-1:0]    fill_q [UsedBuckets];

	logic [KEY_W-1:0]   rd_key_q;
	logic [HandleW-1:0] rd_hdl_q;
	logic [KEY_W+HandleW-1:0] slot_mem [SlotTotal];

	logic                     out_valid_q;
	logic [1:0]               status_q;
	logic [HANDLE_PORT_W-1:0] found_handle_q;

	logic [RemW-1:0]    eff_in;
	logic [RemW-1:0]    rem_d;
	logic [BucketW-1:0] bucket_sel;

	logic                     mem_we;
	logic [AddrW-1:0]         mem_waddr;
	logic [KEY_W+HandleW-1:0] mem_wdata;
	logic [AddrW-1:0]         mem_raddr;
	logic                     fill_we;
	logic [CntW-1:0]          fill_wdata;
	logic                     st_load;
	logic [1:0]               st_d;
	logic                     res_load;
	logic                     k_inc;
	logic                     out_load;

	// A zero count acts as one bucket; a count above the table acts as its size.
	always_comb begin
		if (cfg_q == '0) begin
			eff_in = RemW'(1);
		end else if (cfg_q > RemW'(UsedBuckets)) begin
			eff_in = RemW'(UsedBuckets);
		end else begin
			eff_in = cfg_q;
		end
	end

	// Restoring remainder, several key bits per cycle; the key rotates back to itself.
	always_comb begin
		logic [RemW:0] t;
		rem_d = rem_q;
		for (int i = 0; i < DIV_STEP_BITS; i++) begin
			t = {rem_d, key_q[KEY_W-1-i]};
			if (t >= {1'b0, eff_q}) begin
				t = t - {1'b0, eff_q};
			end
			rem_d = t[RemW-1:0];
		end
	end

	assign bucket_sel = rem_q[BucketW-1:0];

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = base_q + AddrW'(fill_cur_q);
		mem_wdata  = {key_q, hdl_q};
		mem_raddr  = base_q + AddrW'(k_q);
		fill_we    = 1'b0;
		fill_wdata = fill_cur_q + CntW'(1);
		st_load    = 1'b0;
		st_d       = ST_MISS;
		res_load   = 1'b0;
		k_inc      = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				unique case (act_q)
					ACT_ADD: begin
						st_load = 1'b1;
						state_d = S_RESP;
						if (fill_cur_q == CntW'(BUCKET_DEPTH)) begin
							st_d = ST_FULL;
						end else begin
							st_d    = ST_OK;
							mem_we  = 1'b1;
							fill_we = 1'b1;
						end
					end
					ACT_GET, ACT_REMOVE: begin
						state_d = S_SCAN_RD;
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end
			S_SCAN_RD: begin
				if (k_q >= fill_cur_q) begin
					state_d = S_RESP;
				end else begin
					state_d = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				if (rd_key_q == key_q) begin
					st_load  = 1'b1;
					st_d     = ST_OK;
					res_load = 1'b1;
					state_d  = (act_q == ACT_REMOVE) ? S_SHIFT_RD : S_RESP;
				end else begin
					k_inc   = 1'b1;
					state_d = S_SCAN_RD;
				end
			end
			S_SHIFT_RD: begin
				mem_raddr = base_q + AddrW'(k_q + CntW'(1));
				if ((k_q + CntW'(1)) < fill_cur_q) begin
					state_d = S_SHIFT_WR;
				end else begin
					fill_we    = 1'b1;
					fill_wdata = fill_cur_q - CntW'(1);
					state_d    = S_RESP;
				end
			end
			S_SHIFT_WR: begin
				mem_we    = 1'b1;
				mem_waddr = base_q + AddrW'(k_q);
				mem_wdata = {rd_key_q, rd_hdl_q};
				k_inc     = 1'b1;
				state_d   = S_SHIFT_RD;
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cfg_q       <= BUCKET_COUNT_RST;
			out_valid_q <= 1'b0;
			for (int b = 0; b < UsedBuckets; b++) begin
				fill_q[b] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				cfg_q <= wr_data;
			end
			if (fill_we) begin
				fill_q[bucket_q] <= fill_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			act_q     <= action;
			key_q     <= seq_key;
			hdl_q     <= entry_handle[HandleW-1:0];
			eff_q     <= eff_in;
			rem_q     <= '0;
			div_cnt_q <= '0;
			st_q      <= ST_MISS;
			res_q     <= '0;
		end
		if (state_q == S_DIV) begin
			rem_q     <= rem_d;
			key_q     <= {key_q[KEY_W-DIV_STEP_BITS-1:0], key_q[KEY_W-1 -: DIV_STEP_BITS]};
			div_cnt_q <= div_cnt_q + DivCntW'(1);
		end
		if (state_q == S_PREP) begin
			bucket_q   <= bucket_sel;
			base_q     <= AddrW'(bucket_sel) * AddrW'(BUCKET_DEPTH);
			fill_cur_q <= fill_q[bucket_sel];
			k_q        <= '0;
		end
		if (k_inc) begin
			k_q <= k_q + CntW'(1);
		end
		if (st_load) begin
			st_q <= st_d;
		end
		if (res_load) begin
			res_q <= rd_hdl_q;
		end
		if (out_load) begin
			status_q       <= st_q;
			found_handle_q <= HANDLE_PORT_W'(res_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_waddr] <= mem_wdata;
		end
		{rd_key_q, rd_hdl_q} <= slot_mem[mem_raddr];
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign found_handle = found_handle_q;

endmodule
`default_nettype wire
